>>> src/tcdl_pkg.sv
package tcdl_pkg;

  localparam int DEPTH    = 256;
  localparam int DEPTH_W  = $clog2(DEPTH);
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int SUM_W    = CNT_W + 1;

  localparam int STAMP_W  = 48;
  localparam int VALUE_W  = 32;
  localparam int LAT_W    = 24;
  localparam int EXTRA_W  = 25;
  localparam int TOTAL_W  = LAT_W + 1;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_PULL = 1'b1;

  typedef struct packed {
    logic [STAMP_W-1:0]        stamp;
    logic signed [VALUE_W-1:0] value;
  } entry_t;

  // shift: every cell takes its upstream neighbor this cycle
  typedef struct packed {
    logic shift;
  } chain_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_SCAN
  } state_t;

endpackage

>>> src/tcdl_cell.sv
module tcdl_cell
  import tcdl_pkg::*;
(
  input  logic       clk,
  input  chain_ctl_t ctl,
  input  entry_t     d,
  output entry_t     q
);

  entry_t entry_r;

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      entry_r <= d;
    end
  end

  assign q = entry_r;

endmodule

>>> src/tcdl_ctrl.sv
module tcdl_ctrl
  import tcdl_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic                      in_cmd,
  input  logic signed [VALUE_W-1:0] in_command_value,
  input  logic [STAMP_W-1:0]        in_time_us,
  input  logic signed [EXTRA_W-1:0] in_extra_latency,
  output logic                      out_valid,
  output logic signed [VALUE_W-1:0] out_held_value,
  input  logic                      cfg_we,
  input  logic [LAT_W-1:0]          cfg_wdata,
  input  entry_t                    head,
  input  entry_t                    tap,
  output entry_t                    feed,
  output chain_ctl_t                ctl
);

  state_t                    state_r, state_nxt;
  logic [CNT_W-1:0]          count_r, count_nxt;
  logic [LAT_W-1:0]          lat_r;
  logic [STAMP_W-1:0]        now_r, now_nxt;
  logic [TOTAL_W-1:0]        total_r, total_nxt;
  logic [STAMP_W-1:0]        cutoff_r, cutoff_nxt;
  logic [DEPTH_W-1:0]        k_r, k_nxt;
  logic                      stop_r, stop_nxt;
  logic signed [VALUE_W-1:0] held_r, held_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [TOTAL_W-1:0]        extra_clamped;
  logic [STAMP_W-1:0]        total_ext;
  logic                      tap_valid;

  assign extra_clamped = in_extra_latency[EXTRA_W-1] ? '0
                         : TOTAL_W'(in_extra_latency[EXTRA_W-2:0]);
  assign total_ext = STAMP_W'(total_r);

  // tap shows the entry that sat at cell DEPTH-1-k before the scan began;
  // live entries occupy cells 0..count-1, oldest at the far end
  assign tap_valid = (SUM_W'(k_r) + SUM_W'(count_r)) >= SUM_W'(DEPTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      lat_r       <= '0;
      held_r      <= '0;
      out_valid_r <= 1'b0;
      k_r         <= '0;
      stop_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      held_r      <= held_nxt;
      out_valid_r <= out_valid_nxt;
      k_r         <= k_nxt;
      stop_r      <= stop_nxt;
      if (cfg_we) begin
        lat_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    now_r    <= now_nxt;
    total_r  <= total_nxt;
    cutoff_r <= cutoff_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    now_nxt       = now_r;
    total_nxt     = total_r;
    cutoff_nxt    = cutoff_r;
    k_nxt         = k_r;
    stop_nxt      = stop_r;
    held_nxt      = held_r;
    out_valid_nxt = 1'b0;
    feed          = tap;
    ctl.shift     = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_cmd == CMD_PUSH) begin
            // shifting drops the far cell, which is the oldest when full
            feed.stamp = in_time_us;
            feed.value = in_command_value;
            ctl.shift  = 1'b1;
            if (count_r != CNT_W'(DEPTH)) begin
              count_nxt = count_r + 1'b1;
            end
          end else begin
            now_nxt   = in_time_us;
            total_nxt = TOTAL_W'(lat_r) + extra_clamped;
            state_nxt = ST_EVAL;
          end
        end
      end
      ST_EVAL: begin
        if (total_r == '0) begin
          if (count_r != '0) begin
            held_nxt = head.value;
          end
          count_nxt     = '0;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else if (now_r >= total_ext) begin
          cutoff_nxt = now_r - total_ext;
          k_nxt      = '0;
          stop_nxt   = 1'b0;
          state_nxt  = ST_SCAN;
        end else begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_SCAN: begin
        // rotate the ring once around; it ends where it started
        ctl.shift = 1'b1;
        feed      = tap;
        if (tap_valid && !stop_r) begin
          if (tap.stamp <= cutoff_r) begin
            held_nxt = tap.value;
          end else begin
            stop_nxt = 1'b1;
          end
        end
        k_nxt = k_r + 1'b1;
        if (k_r == DEPTH_W'(DEPTH - 1)) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy           = (state_r != ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_held_value = held_r;

endmodule

>>> src/timestamped_command_delay_line.sv
// channel | ports                                            | beat taken when
// --------+--------------------------------------------------+-----------------------
// input   | start, busy, in_cmd, in_command_value,           | start && !busy
//         | in_time_us, in_extra_latency                     |
// result  | out_valid, out_held_value                        | out_valid (one cycle)
// config  | cfg_we, cfg_wdata (transport delay, us)          | cfg_we
//
// A push shifts the whole cell row and busy stays low.
// A pull whose delay has elapsed holds busy through ST_EVAL, which forms the
// cutoff, then ST_SCAN, which rotates the row once around past a single compare
// tap; the strobe follows. Other pulls hold busy only in ST_EVAL and strobe in
// the cycle after it. Synchronous active-low reset clears control, count,
// latency and the held value; cells hold no reset; no stalls.
module timestamped_command_delay_line
  import tcdl_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic                      in_cmd,
  input  logic signed [VALUE_W-1:0] in_command_value,
  input  logic [STAMP_W-1:0]        in_time_us,
  input  logic signed [EXTRA_W-1:0] in_extra_latency,
  output logic                      out_valid,
  output logic signed [VALUE_W-1:0] out_held_value,
  input  logic                      cfg_we,
  input  logic [LAT_W-1:0]          cfg_wdata
);

  entry_t     cell_q [DEPTH];
  entry_t     feed;
  chain_ctl_t ctl;

  tcdl_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_cmd           (in_cmd),
    .in_command_value (in_command_value),
    .in_time_us       (in_time_us),
    .in_extra_latency (in_extra_latency),
    .out_valid        (out_valid),
    .out_held_value   (out_held_value),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .head             (cell_q[0]),
    .tap              (cell_q[DEPTH-1]),
    .feed             (feed),
    .ctl              (ctl)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      tcdl_cell u_cell (
        .clk (clk),
        .ctl (ctl),
        .d   (feed),
        .q   (cell_q[i])
      );
    end else begin : g_rest
      tcdl_cell u_cell (
        .clk (clk),
        .ctl (ctl),
        .d   (cell_q[i-1]),
        .q   (cell_q[i])
      );
    end
  end

endmodule

>>> src/tcdl_checker.sv
module tcdl_checker
  import tcdl_pkg::*;
(
  input logic                      clk,
  input logic                      rst_n,
  input logic                      start,
  input logic                      busy,
  input logic                      in_cmd,
  input logic                      out_valid,
  input logic signed [VALUE_W-1:0] out_held_value
);

  // a result only closes out a pull that kept the block busy
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without a pending pull");

  a_idle_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("busy while presenting a result");

  a_push_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_cmd == CMD_PUSH) |=> (!busy && !out_valid))
    else $error("push stalled the block or gave a result");

  a_pull_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_cmd == CMD_PULL) |=> busy)
    else $error("pull did not go busy");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> (!out_valid && $stable(out_held_value)))
    else $error("result strobe longer than one cycle");

endmodule

bind timestamped_command_delay_line tcdl_checker u_tcdl_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .in_cmd         (in_cmd),
  .out_valid      (out_valid),
  .out_held_value (out_held_value)
);

>>> bench/tcdl_held_value_checker.sv
module tcdl_held_value_checker
  import tcdl_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic                      busy,
  input  logic                      in_cmd,
  input  logic signed [VALUE_W-1:0] in_command_value,
  input  logic [STAMP_W-1:0]        in_time_us,
  input  logic signed [EXTRA_W-1:0] in_extra_latency,
  input  logic                      out_valid,
  input  logic signed [VALUE_W-1:0] out_held_value,
  input  logic                      cfg_we,
  input  logic [LAT_W-1:0]          cfg_wdata,
  output int                        mismatch_count,
  output int                        held_pending,
  output int                        held_checked
);

  logic [STAMP_W-1:0]        ring_stamp [DEPTH];
  logic signed [VALUE_W-1:0] ring_value [DEPTH];
  int                        ring_head;
  int                        ring_fill;
  logic signed [VALUE_W-1:0] held_cmd;
  logic [LAT_W-1:0]          latency_us;
  logic signed [VALUE_W-1:0] held_value_q [$];
  int                        errs = 0;
  int                        seen = 0;

  // full ring: overwrite the oldest slot and move the head past it
  function automatic void store_command(input logic [STAMP_W-1:0] stamp,
                                        input logic signed [VALUE_W-1:0] value);
    int slot;
    if (ring_fill >= DEPTH) begin
      slot = ring_head;
      ring_head = (ring_head + 1) % DEPTH;
    end else begin
      slot = (ring_head + ring_fill) % DEPTH;
      ring_fill++;
    end
    ring_stamp[slot] = stamp;
    ring_value[slot] = value;
  endfunction

  function automatic logic signed [VALUE_W-1:0] delayed_command(
      input logic [STAMP_W-1:0] now, input logic signed [EXTRA_W-1:0] extra);
    logic [TOTAL_W:0]   delay;
    logic [STAMP_W-1:0] cutoff;
    int                 slot;
    delay = {2'b00, latency_us};
    if (!extra[EXTRA_W-1]) delay = delay + extra[EXTRA_W-2:0];
    if (delay == 0) begin
      if (ring_fill > 0) begin
        held_cmd = ring_value[(ring_head + ring_fill - 1) % DEPTH];
        ring_fill = 0;
      end
    end else if (now >= delay) begin
      cutoff = now - delay;
      // stop at the first stamp past the cutoff, even if older stamps follow
      for (int i = 0; i < ring_fill; i++) begin
        slot = (ring_head + i) % DEPTH;
        if (ring_stamp[slot] > cutoff) break;
        held_cmd = ring_value[slot];
      end
    end
    return held_cmd;
  endfunction

  always @(posedge clk) begin
    logic signed [VALUE_W-1:0] want;
    if (!rst_n) begin
      ring_head = 0;
      ring_fill = 0;
      held_cmd = '0;
      latency_us = '0;
      held_value_q.delete();
    end else begin
      if (out_valid) begin
        if (held_value_q.size() == 0) begin
          $error("held_value: unexpected result beat, actual %0d", out_held_value);
          errs++;
        end else begin
          want = held_value_q[0];
          held_value_q.delete(0);
          seen++;
          if (out_held_value !== want) begin
            $error("held_value mismatch: expected %0d, actual %0d", want, out_held_value);
            errs++;
          end
        end
      end
      if (cfg_we) latency_us = cfg_wdata;
      if (start && !busy) begin
        if (in_cmd == CMD_PUSH) store_command(in_time_us, in_command_value);
        else held_value_q.push_back(delayed_command(in_time_us, in_extra_latency));
      end
    end
    mismatch_count <= errs;
    held_pending <= held_value_q.size();
    held_checked <= seen;
  end

endmodule

>>> bench/timestamped_command_delay_line_tb.sv
module timestamped_command_delay_line_tb;
  import tcdl_pkg::*;

  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int PHASES          = 8;
  localparam int BEATS_PER_PHASE = 15;
  localparam int FILL_BURST      = DEPTH + 8;

  localparam logic [STAMP_W-1:0]        TIME_MAX  = '1;
  localparam logic [LAT_W-1:0]          LAT_MAX   = '1;
  localparam logic signed [EXTRA_W-1:0] EXTRA_MAX = {1'b0, {(EXTRA_W-1){1'b1}}};
  localparam logic signed [EXTRA_W-1:0] EXTRA_MIN = {1'b1, {(EXTRA_W-2){1'b0}}, 1'b1};
  localparam logic signed [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      start;
  logic                      busy;
  logic                      in_cmd;
  logic signed [VALUE_W-1:0] in_command_value;
  logic [STAMP_W-1:0]        in_time_us;
  logic signed [EXTRA_W-1:0] in_extra_latency;
  logic                      out_valid;
  logic signed [VALUE_W-1:0] out_held_value;
  logic                      cfg_we;
  logic [LAT_W-1:0]          cfg_wdata;

  int                 mismatch_count;
  int                 held_pending;
  int                 held_checked;
  int                 cycle_count = 0;
  int                 beats_sent = 0;
  int                 idle_pct = 0;
  logic [STAMP_W-1:0] now_us = '0;

  always #4 clk = ~clk;

  timestamped_command_delay_line i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_cmd          (in_cmd),
    .in_command_value(in_command_value),
    .in_time_us      (in_time_us),
    .in_extra_latency(in_extra_latency),
    .out_valid       (out_valid),
    .out_held_value  (out_held_value),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata)
  );

  tcdl_held_value_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_cmd          (in_cmd),
    .in_command_value(in_command_value),
    .in_time_us      (in_time_us),
    .in_extra_latency(in_extra_latency),
    .out_valid       (out_valid),
    .out_held_value  (out_held_value),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .mismatch_count  (mismatch_count),
    .held_pending    (held_pending),
    .held_checked    (held_checked)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d held values outstanding",
               cycle_count, held_pending);
      $display("timestamped_command_delay_line regression: fail");
      $finish;
    end
  end

  // start stays high between back-to-back beats; it only drops in an idle cycle
  task automatic send_beat(input logic cmd, input logic signed [VALUE_W-1:0] value,
                           input logic [STAMP_W-1:0] stamp,
                           input logic signed [EXTRA_W-1:0] extra);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_cmd <= cmd;
    in_command_value <= value;
    in_time_us <= stamp;
    in_extra_latency <= extra;
    do @(posedge clk); while (busy);
    beats_sent++;
  endtask

  task automatic wait_results_done;
    start <= 1'b0;
    do @(posedge clk); while (held_pending != 0);
  endtask

  task automatic write_latency(input logic [LAT_W-1:0] lat);
    wait_results_done();
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= lat;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [STAMP_W-1:0] later(input logic [STAMP_W-1:0] t,
                                              input logic [STAMP_W-1:0] dt);
    return (TIME_MAX - t < dt) ? TIME_MAX : t + dt;
  endfunction

  task automatic random_beat(input int unsigned step_max);
    logic [STAMP_W-1:0]        stamp;
    logic signed [EXTRA_W-1:0] extra;
    int unsigned               back;
    now_us = later(now_us, STAMP_W'($urandom_range(step_max)));
    if ($urandom_range(99) < 60) begin
      stamp = now_us;
      if ($urandom_range(9) == 0) begin
        back = $urandom_range(step_max * 4);
        stamp = (now_us > back) ? now_us - back : '0;
      end
      send_beat(CMD_PUSH, $urandom, stamp, EXTRA_W'($urandom));
    end else begin
      case ($urandom_range(9))
        0, 1, 2, 3: extra = EXTRA_W'($urandom_range(step_max * 8));
        4:          extra = EXTRA_W'(-int'($urandom_range(1, 16777215)));
        5:          extra = EXTRA_W'(int'($urandom_range(0, 33554430)) - 16777215);
        6:          extra = EXTRA_MAX;
        default:    extra = '0;
      endcase
      send_beat(CMD_PULL, $urandom, now_us, extra);
    end
  endtask

  initial begin
    int unsigned step_max;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_cmd <= CMD_PUSH;
    in_command_value <= '0;
    in_time_us <= '0;
    in_extra_latency <= '0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // zero delay: empty ring, newest wins and empties, negative extra clamps
    send_beat(CMD_PULL, '0, '0, '0);
    send_beat(CMD_PUSH, VALUE_MAX, '0, EXTRA_MAX);
    send_beat(CMD_PUSH, VALUE_MIN, 48'd5, EXTRA_MIN);
    send_beat(CMD_PULL, '0, 48'd5, '0);
    send_beat(CMD_PULL, '0, 48'd6, '0);
    send_beat(CMD_PUSH, 32'sd77, 48'd7, '0);
    send_beat(CMD_PULL, '0, 48'd8, -25'sd1);
    send_beat(CMD_PULL, '0, 48'd9, EXTRA_MIN);

    write_latency(24'd100);
    send_beat(CMD_PUSH, 32'sd1, 48'd10, '0);
    send_beat(CMD_PUSH, 32'sd2, 48'd200, '0);
    send_beat(CMD_PULL, '0, 48'd50, '0);      // delay not elapsed
    send_beat(CMD_PULL, '0, 48'd100, '0);     // cutoff 0, nothing old enough
    send_beat(CMD_PULL, '0, 48'd110, '0);
    send_beat(CMD_PUSH, 32'sd3, 48'd150, '0); // stamp behind its predecessor
    send_beat(CMD_PULL, '0, 48'd250, '0);     // scan stops at stamp 200
    send_beat(CMD_PULL, '0, 48'd400, '0);
    send_beat(CMD_PULL, '0, TIME_MAX, EXTRA_MAX);
    send_beat(CMD_PUSH, 32'sh1234_5678, TIME_MAX, '0);
    send_beat(CMD_PULL, '0, TIME_MAX, '0);

    write_latency(LAT_MAX);
    send_beat(CMD_PULL, '0, 48'd100, EXTRA_MAX);
    send_beat(CMD_PULL, '0, TIME_MAX, EXTRA_MAX);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0, 5:    write_latency('0);
        1, 7:    write_latency(LAT_MAX);
        3:       write_latency(LAT_W'($urandom_range(1, 64)));
        6:       write_latency(LAT_W'($urandom_range(1, 4096)));
        default: write_latency(LAT_W'($urandom));
      endcase
      case (p % 4)
        1:       now_us = STAMP_W'({$urandom, $urandom});
        2:       now_us = TIME_MAX - $urandom_range(0, 1 << 30);
        3:       now_us = STAMP_W'($urandom_range(0, 1000));
        default: ;
      endcase
      case (p % 4)
        1:       idle_pct = 80;
        3:       idle_pct = 15;
        default: idle_pct = 0;
      endcase
      // cfg_wdata still holds the latency written for this phase
      step_max = 32'(cfg_wdata >> 4) + 32'd32;
      if (step_max > (1 << 20)) step_max = 1 << 20;

      // overrun the ring so the oldest entries get dropped
      if (p == 4) begin
        for (int n = 0; n < FILL_BURST; n++) begin
          now_us = later(now_us, STAMP_W'($urandom_range(step_max)));
          send_beat(CMD_PUSH, $urandom, now_us, EXTRA_W'($urandom));
        end
      end
      for (int n = 0; n < BEATS_PER_PHASE; n++) begin
        if ($urandom_range(29) == 0) wait_results_done();
        random_beat(step_max);
      end
    end

    wait_results_done();
    repeat (2 * DEPTH) @(posedge clk);
    $display("covered %0d beats over %0d latency settings incl. zero and full scale,",
             beats_sent, PHASES + 3);
    $display("a %0d-push ring overrun, %0d held values checked, %0d mismatches",
             FILL_BURST, held_checked, mismatch_count);
    if (mismatch_count == 0 && held_pending == 0) begin
      $display("timestamped_command_delay_line regression: pass");
    end else begin
      $display("timestamped_command_delay_line regression: fail");
    end
    $finish;
  end

endmodule
